[src/pct_enc_pkg.sv]
// Shared types, constants and helper functions for the percent encoder.
// Used by every module under src; depends on nothing.
package pct_enc_pkg;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Register map of the configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ENCODE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PASS_MASK   = 2'd1;

    localparam int NUM_RESERVED = 20;
    localparam logic [7:0] PCT_CHAR = 8'h25;

    // Reserved characters in pass_mask bit order
    localparam logic [7:0] RESERVED_CHARS [NUM_RESERVED] = '{
        8'h3A, 8'h40, 8'h26, 8'h3D, 8'h3F, 8'h23, 8'h28, 8'h29, 8'h5B, 8'h5D,
        8'h27, 8'h2F, 8'h2B, 8'h21, 8'h2A, 8'h3B, 8'h24, 8'h2C, 8'h25, 8'h20
    };

    typedef struct packed {
        logic [1:0]              encode_mode;
        logic [NUM_RESERVED-1:0] pass_mask;
    } cfg_t;

    // One classified input word waiting for expansion
    typedef struct packed {
        logic [7:0] byte_in;
        logic       esc;
        logic       last_byte;
    } item_t;

    // Uppercase ASCII hex digit of a nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] d;
        if (n < 4'd10)
            d = 8'h30 + {4'd0, n};
        else
            d = 8'h37 + {4'd0, n};
        return d;
    endfunction

    // One bit per reserved character that matches c
    function automatic logic [NUM_RESERVED-1:0] reserved_match(input logic [7:0] c);
        logic [NUM_RESERVED-1:0] m;
        for (int i = 0; i < NUM_RESERVED; i++)
            m[i] = (RESERVED_CHARS[i] == c);
        return m;
    endfunction

    // Length of a UTF-8 sequence opened by c; 0 when c is no lead byte
    function automatic logic [2:0] lead_length(input logic [7:0] c);
        logic [2:0] n;
        if (c >= 8'd192 && c <= 8'd223)
            n = 3'd2;
        else if (c >= 8'd224 && c <= 8'd239)
            n = 3'd3;
        else if (c >= 8'd240 && c <= 8'd247)
            n = 3'd4;
        else if (c >= 8'd248 && c <= 8'd251)
            n = 3'd5;
        else if (c == 8'd252 || c == 8'd253)
            n = 3'd6;
        else
            n = 3'd0;
        return n;
    endfunction

endpackage

[src/pct_enc_front.sv]
// Front part: accepts input words and classifies them for the reserved stage.
// Depends on pct_enc_pkg.
module pct_enc_front (
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] byte_in
    input  logic                  s_tlast,   // last_byte
    input  pct_enc_pkg::cfg_t     cfg,
    input  logic                  q_full,
    output logic                  q_push,
    output pct_enc_pkg::item_t    q_item
);
    import pct_enc_pkg::*;

    logic [NUM_RESERVED-1:0] match;
    logic                    do_reserved;

    // Accept while the queue has room
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // Escape a reserved character unless its pass bit is set or encode_mode bit 1 is set
    assign do_reserved = !cfg.encode_mode[1];
    assign match       = reserved_match(s_tdata);

    always_comb
    begin
        q_item.byte_in   = s_tdata;
        q_item.last_byte = s_tlast;
        q_item.esc       = do_reserved && ((match & ~cfg.pass_mask) != '0);
    end

endmodule

[src/pct_enc_queue.sv]
// Short register queue between the front and back parts.
// Depends on pct_enc_pkg.
module pct_enc_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  pct_enc_pkg::item_t    push_item,
    output logic                  full,
    input  logic                  pop,
    output logic                  valid,
    output pct_enc_pkg::item_t    head
);
    import pct_enc_pkg::*;

    item_t                 mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;

    assign full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

[src/pct_enc_back.sv]
// Back part: expands each queued word into output bytes through the reserved and
// UTF-8 stages, one byte per cycle into an output register unless stalled. Depends on pct_enc_pkg.
module pct_enc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pct_enc_pkg::cfg_t     cfg,
    input  logic                  q_valid,
    input  pct_enc_pkg::item_t    q_item,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] out_byte
    output logic                  m_tlast,   // run_last
    output logic                  m_tuser    // [0] stream_end
);
    import pct_enc_pkg::*;

    logic [1:0] s1_cnt_reg, s1_cnt_next;
    logic [1:0] s2_cnt_reg, s2_cnt_next;
    logic       esc2_reg, esc2_next;
    logic [2:0] pend_reg, pend_next;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_data_reg;
    logic       m_last_reg;
    logic       m_end_reg;

    logic       do_utf8;
    logic [7:0] s1_byte;
    logic       s1_last;
    logic [2:0] lead_len;
    logic       esc2_now;
    logic       s2_last;
    logic [7:0] out_byte;
    logic       load_ok;
    logic       fire;
    logic       item_done;

    assign do_utf8 = !cfg.encode_mode[0];

    // Select the reserved-stage byte at the current position
    always_comb
    begin
        if (q_item.esc)
        begin
            unique case (s1_cnt_reg)
                2'd0:    s1_byte = PCT_CHAR;
                2'd1:    s1_byte = hex_digit(q_item.byte_in[7:4]);
                default: s1_byte = hex_digit(q_item.byte_in[3:0]);
            endcase
        end
        else
        begin
            s1_byte = q_item.byte_in;
        end
        s1_last = q_item.esc ? (s1_cnt_reg == 2'd2) : (s1_cnt_reg == 2'd0);
    end

    // Decide the UTF-8 escape on the first sub-byte, hold it after
    assign lead_len = lead_length(s1_byte);
    assign esc2_now = (s2_cnt_reg == 2'd0)
                      ? (do_utf8 && (pend_reg != 3'd0 || lead_len > 3'd1))
                      : esc2_reg;
    assign s2_last  = esc2_now ? (s2_cnt_reg == 2'd2) : 1'b1;

    always_comb
    begin
        if (esc2_now)
        begin
            unique case (s2_cnt_reg)
                2'd0:    out_byte = PCT_CHAR;
                2'd1:    out_byte = hex_digit(s1_byte[7:4]);
                default: out_byte = hex_digit(s1_byte[3:0]);
            endcase
        end
        else
        begin
            out_byte = s1_byte;
        end
    end

    // Produce a byte whenever a word is queued and the output register is free or draining
    assign load_ok   = !m_valid_reg || m_tready;
    assign fire      = q_valid && load_ok;
    assign item_done = s1_last && s2_last;
    assign q_pop     = fire && item_done;

    // Advance position counters and pending count
    always_comb
    begin
        s1_cnt_next  = s1_cnt_reg;
        s2_cnt_next  = s2_cnt_reg;
        esc2_next    = esc2_reg;
        pend_next    = pend_reg;
        m_valid_next = m_valid_reg && !m_tready;
        if (fire)
        begin
            m_valid_next = 1'b1;
            if (s2_cnt_reg == 2'd0)
                esc2_next = esc2_now;
            if (s2_last)
            begin
                s2_cnt_next = 2'd0;
                s1_cnt_next = s1_last ? 2'd0 : s1_cnt_reg + 2'd1;
            end
            else
            begin
                s2_cnt_next = s2_cnt_reg + 2'd1;
            end
            if (s2_cnt_reg == 2'd0 && do_utf8)
            begin
                if (pend_reg != 3'd0)
                    pend_next = pend_reg - 3'd1;
                else if (lead_len > 3'd1)
                    pend_next = lead_len - 3'd1;
            end
            if (item_done && q_item.last_byte)
                pend_next = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_cnt_reg  <= '0;
            s2_cnt_reg  <= '0;
            esc2_reg    <= 1'b0;
            pend_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            s1_cnt_reg  <= s1_cnt_next;
            s2_cnt_reg  <= s2_cnt_next;
            esc2_reg    <= esc2_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Load the output word
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            m_data_reg <= out_byte;
            m_last_reg <= item_done;
            m_end_reg  <= item_done && q_item.last_byte;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_end_reg;

    // A continuation never asks for more than five further bytes
    a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 3'd5)
        else $error("utf8 pending count out of range");

    // Hex sub-bytes only follow a UTF-8 escape of the same queued word
    a_sub_byte: assert property (@(posedge clk) disable iff (!rst_n)
        s2_cnt_reg != 2'd0 |-> esc2_reg && q_valid)
        else $error("sub-byte position without escape or word");

    // Reserved-stage positions past the first only exist for escaped words
    a_s1_pos: assert property (@(posedge clk) disable iff (!rst_n)
        s1_cnt_reg != 2'd0 |-> q_valid && q_item.esc)
        else $error("reserved-stage position without escaped word");

    // A finished final word leaves the queue with the end mark on its last byte
    a_end_mark: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && q_item.last_byte |=> m_tvalid && m_tlast && m_tuser)
        else $error("stream end not marked on final byte");

endmodule

[src/percent_encoder_core.sv]
// Top level of the streaming URI percent encoder: configuration registers,
// front classifier, queue and back expander. Depends on pct_enc_pkg.
//
// Each input word (one string byte, tlast on the final byte) yields 1 to 9
// output words, emitted through a registered output stage one per clock while
// the output is not stalled: 1 for a plain byte, 3 for a byte escaped once, 9
// for a reserved character that is escaped again inside a UTF-8 sequence. The
// output word rate of the back expander sets the pace; a four-word queue lets
// input be taken while output is stalled. Hex digits are uppercase. Write
// configuration only while no word is in flight.
module percent_encoder_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] byte_in
    input  logic                                s_tlast,   // last_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // [7:0] out_byte
    output logic                                m_tlast,   // run_last
    output logic                                m_tuser,   // [0] stream_end
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pct_enc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pct_enc_pkg::NUM_RESERVED-1:0] cfg_data
);
    import pct_enc_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  q_full;
    logic  q_push;
    item_t q_in;
    logic  q_pop;
    logic  q_valid;
    item_t q_head;

    // Take configuration writes at any time
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            if (cfg_index == REG_ENCODE_MODE)
                cfg_next.encode_mode = cfg_data[1:0];
            else if (cfg_index == REG_PASS_MASK)
                cfg_next.pass_mask = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    pct_enc_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_in)
    );

    pct_enc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    pct_enc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
